/* rtl/lmatp_pkg.sv */
// shared constants, types and helpers of the lightmap atlas texel packer
package lmatp_pkg;

    localparam int BLOCK_SIDE    = 128;
    localparam int MAX_GRID_SIDE = 16;

    localparam int BLOCK_BITS    = $clog2(BLOCK_SIDE);
    localparam int GRID_BITS     = $clog2(MAX_GRID_SIDE + 1);
    localparam int SLOT_COL_BITS = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
    localparam int POS_BITS      = SLOT_COL_BITS + BLOCK_BITS;
    localparam int WIDTH_BITS    = GRID_BITS + BLOCK_BITS;
    localparam int PROD_BITS     = POS_BITS + WIDTH_BITS;

    localparam int CFG_BITS      = 5;
    localparam int CHAN_BITS     = 8;
    localparam int PIX_BITS      = 22;
    localparam int S_DATA_BITS   = 24;
    localparam int M_DATA_BITS   = 56;

    localparam logic [BLOCK_BITS-1:0] BLOCK_LAST = BLOCK_BITS'(BLOCK_SIDE - 1);
    localparam logic [GRID_BITS-1:0]  GRID_MAX   = GRID_BITS'(MAX_GRID_SIDE);
    localparam logic [CHAN_BITS-1:0]  CHAN_FULL  = 8'hFF;

    // texel kinds carried on the input tuser
    localparam logic OP_WHITE    = 1'b0;
    localparam logic OP_LIGHTMAP = 1'b1;

    // texel and position snapshot taken at the input transfer
    typedef struct packed {
        logic                     op;
        logic [CHAN_BITS-1:0]     red;
        logic [CHAN_BITS-1:0]     green;
        logic [CHAN_BITS-1:0]     blue;
        logic [BLOCK_BITS-1:0]    texel_col;
        logic [BLOCK_BITS-1:0]    texel_row;
        logic [SLOT_COL_BITS-1:0] slot_col;
        logic [GRID_BITS-1:0]     slot_row;
        logic [GRID_BITS-1:0]     grid;
        logic                     block_end;
        logic                     outside_grid;
    } texel_snap_t;

    typedef struct packed {
        logic [PIX_BITS-1:0]  pixel_index;
        logic [CHAN_BITS-1:0] out_red;
        logic [CHAN_BITS-1:0] out_green;
        logic [CHAN_BITS-1:0] out_blue;
        logic [CHAN_BITS-1:0] out_alpha;
        logic                 block_end;
        logic                 outside_grid;
    } texel_out_t;

    // channel times four, saturated
    function automatic logic [CHAN_BITS-1:0] overbright(input logic [CHAN_BITS-1:0] c);
        logic [CHAN_BITS+1:0] v;
        v = {c, 2'b00};
        overbright = (v[CHAN_BITS+1:CHAN_BITS] != 2'b00) ? CHAN_FULL : v[CHAN_BITS-1:0];
    endfunction

    // zero means one, large values clip to the largest grid
    function automatic logic [GRID_BITS-1:0] eff_grid(input logic [CFG_BITS-1:0] g);
        logic [GRID_BITS-1:0] r;
        if (g == '0) begin
            r = GRID_BITS'(1);
        end else if (CFG_BITS'(MAX_GRID_SIDE) < g) begin
            r = GRID_MAX;
        end else begin
            r = GRID_BITS'(g);
        end
        eff_grid = r;
    endfunction

endpackage

/* rtl/lightmap_atlas_texel_packer_unit.sv */
// top level of the lightmap atlas texel packer
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------------------------
//  s_        | in        | s_tvalid / s_tready  | tdata red,green,blue; tuser op
//  m_        | out       | m_tvalid / m_tready  | tdata index,rgba; tlast block end;
//            |           |                      | tuser outside grid
//  cfg_      | in        | cfg_valid/cfg_ready  | grid_side
//
// one texel per cycle sustained while m_tready stays high; each input transfer passes
// through the input register and then the result register, the only stages.
// reset clears all counters to the first texel of the first slot, grid_side to 1.
// a stalled result holds both stages; each stage frees as soon as it is taken.
// config is always ready and applies from the next texel on.
module lightmap_atlas_texel_packer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lmatp_pkg::S_DATA_BITS-1:0] s_tdata,  // red, green, blue
    input  logic                              s_tuser,  // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lmatp_pkg::M_DATA_BITS-1:0] m_tdata,  // pixel_index, out_red, out_green,
                                                        // out_blue, out_alpha, zero fill
    output logic                              m_tlast,  // block_end
    output logic                              m_tuser,  // outside_grid
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lmatp_pkg::CFG_BITS-1:0]    cfg_data
);
    import lmatp_pkg::*;

    logic [CFG_BITS-1:0] grid_side_reg, grid_side_next;
    logic                snap_valid;
    logic                snap_ready;
    texel_snap_t         snap;
    texel_out_t          res;

    assign cfg_ready      = 1'b1;
    assign grid_side_next = (cfg_valid && cfg_ready) ? cfg_data : grid_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_side_reg <= CFG_BITS'(1);
        end else begin
            grid_side_reg <= grid_side_next;
        end
    end

    lmatp_pos_tracker u_pos_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .grid_side  (grid_side_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_op       (s_tuser),
        .s_rgb      (s_tdata),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    lmatp_texel_shade u_texel_shade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {
        (M_DATA_BITS - PIX_BITS - 4*CHAN_BITS)'(0),
        res.out_alpha, res.out_blue, res.out_green, res.out_red, res.pixel_index
    };
    assign m_tlast = res.block_end;
    assign m_tuser = res.outside_grid;

endmodule

/* rtl/lmatp_pos_tracker.sv */
// position counters within block and grid, plus the input register stage
module lmatp_pos_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lmatp_pkg::CFG_BITS-1:0]   grid_side,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             s_op,
    input  logic [lmatp_pkg::S_DATA_BITS-1:0] s_rgb,
    output logic                             snap_valid,
    input  logic                             snap_ready,
    output lmatp_pkg::texel_snap_t           snap
);
    import lmatp_pkg::*;

    logic [BLOCK_BITS-1:0]    texel_col_reg, texel_col_next;
    logic [BLOCK_BITS-1:0]    texel_row_reg, texel_row_next;
    logic [SLOT_COL_BITS-1:0] slot_col_reg, slot_col_next;
    logic [GRID_BITS-1:0]     slot_row_reg, slot_row_next;
    logic                     valid_reg, valid_next;
    texel_snap_t              snap_reg, snap_next;

    logic [GRID_BITS-1:0] grid;
    logic [GRID_BITS-1:0] slot_col_inc;
    logic                 outside;
    logic                 col_wrap;
    logic                 row_wrap;
    logic                 accept;

    assign grid         = eff_grid(grid_side);
    assign slot_col_inc = GRID_BITS'(slot_col_reg) + GRID_BITS'(1);
    assign outside      = (slot_row_reg >= grid) || (GRID_BITS'(slot_col_reg) >= grid);
    assign col_wrap     = (texel_col_reg == BLOCK_LAST);
    assign row_wrap     = (texel_row_reg == BLOCK_LAST);

    assign s_tready   = !valid_reg || snap_ready;
    assign accept     = s_tvalid && s_tready;
    assign snap_valid = valid_reg;
    assign snap       = snap_reg;

    always_comb begin
        texel_col_next = texel_col_reg;
        texel_row_next = texel_row_reg;
        slot_col_next  = slot_col_reg;
        slot_row_next  = slot_row_reg;
        // a texel outside the grid leaves every counter alone
        if (accept && !outside) begin
            if (col_wrap) begin
                texel_col_next = '0;
                if (row_wrap) begin
                    texel_row_next = '0;
                    if (slot_col_inc >= grid) begin
                        slot_col_next = '0;
                        slot_row_next = slot_row_reg + GRID_BITS'(1);
                    end else begin
                        slot_col_next = slot_col_inc[SLOT_COL_BITS-1:0];
                    end
                end else begin
                    texel_row_next = texel_row_reg + BLOCK_BITS'(1);
                end
            end else begin
                texel_col_next = texel_col_reg + BLOCK_BITS'(1);
            end
        end
    end

    always_comb begin
        snap_next              = snap_reg;
        snap_next.op           = s_op;
        snap_next.red          = s_rgb[CHAN_BITS-1:0];
        snap_next.green        = s_rgb[2*CHAN_BITS-1:CHAN_BITS];
        snap_next.blue         = s_rgb[3*CHAN_BITS-1:2*CHAN_BITS];
        snap_next.texel_col    = texel_col_reg;
        snap_next.texel_row    = texel_row_reg;
        snap_next.slot_col     = slot_col_reg;
        snap_next.slot_row     = slot_row_reg;
        snap_next.grid         = grid;
        snap_next.block_end    = col_wrap && row_wrap;
        snap_next.outside_grid = outside;
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (snap_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            texel_col_reg <= '0;
            texel_row_reg <= '0;
            slot_col_reg  <= '0;
            slot_row_reg  <= '0;
            valid_reg     <= 1'b0;
        end else begin
            texel_col_reg <= texel_col_next;
            texel_row_reg <= texel_row_next;
            slot_col_reg  <= slot_col_next;
            slot_row_reg  <= slot_row_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            snap_reg <= snap_next;
        end
    end

endmodule

/* rtl/lmatp_texel_shade.sv */
// pixel index and color computation into the result register
module lmatp_texel_shade (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   snap_valid,
    output logic                   snap_ready,
    input  lmatp_pkg::texel_snap_t snap,
    output logic                   res_valid,
    input  logic                   res_ready,
    output lmatp_pkg::texel_out_t  res
);
    import lmatp_pkg::*;

    logic       valid_reg, valid_next;
    texel_out_t res_reg, res_next;

    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [WIDTH_BITS-1:0] atlas_w;
    logic [PROD_BITS-1:0]  pix_sum;
    logic                  take;

    assign pos_x   = POS_BITS'(snap.slot_col) * POS_BITS'(BLOCK_SIDE) + POS_BITS'(snap.texel_col);
    assign pos_y   = POS_BITS'(snap.slot_row) * POS_BITS'(BLOCK_SIDE) + POS_BITS'(snap.texel_row);
    assign atlas_w = WIDTH_BITS'(snap.grid) * WIDTH_BITS'(BLOCK_SIDE);
    assign pix_sum = PROD_BITS'(pos_y) * PROD_BITS'(atlas_w) + PROD_BITS'(pos_x);

    assign snap_ready = !valid_reg || res_ready;
    assign take       = snap_valid && snap_ready;
    assign res_valid  = valid_reg;
    assign res        = res_reg;

    always_comb begin
        res_next = '0;
        if (snap.outside_grid) begin
            res_next.outside_grid = 1'b1;
        end else begin
            res_next.pixel_index = pix_sum[PIX_BITS-1:0];
            if (snap.op == OP_LIGHTMAP) begin
                res_next.out_red   = overbright(snap.red);
                res_next.out_green = overbright(snap.green);
                res_next.out_blue  = overbright(snap.blue);
            end else begin
                res_next.out_red   = CHAN_FULL;
                res_next.out_green = CHAN_FULL;
                res_next.out_blue  = CHAN_FULL;
            end
            res_next.out_alpha = CHAN_FULL;
            res_next.block_end = snap.block_end;
        end
    end

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

endmodule
